@@ sv/ker_pkg.sv @@
// ----------------------------------------------------------------------------
// ker_pkg
// Shared types and codes of the key event recognizer: sequencer states,
// event codes, register indexes and the per-key state record.
// ----------------------------------------------------------------------------
package ker_pkg;

   // item operation codes
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_SCAN = 1'b1;

   // event codes on the result channel
   localparam logic [2:0] EV_DOWN       = 3'd0;
   localparam logic [2:0] EV_UP         = 3'd1;
   localparam logic [2:0] EV_HOLD       = 3'd2;
   localparam logic [2:0] EV_REPEAT     = 3'd3;
   localparam logic [2:0] EV_LIFT       = 3'd4;
   localparam logic [2:0] EV_CLICK_BASE = 3'd4;

   // highest press count that still has a click code (triple)
   localparam logic [3:0] LAST_CLICK_COUNT = 4'd3;
   // keys at and above this index have no level bit and no enable bits
   localparam int unsigned LEVEL_KEYS = 4;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] REG_HOLD_MS       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_REPEAT_MS     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SETTLE_MS     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_LIFT_MS       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_EVENT_ENABLE  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_PRESSED_LEVEL = 3'd5;

   // register reset values
   localparam logic [15:0] HOLD_MS_RESET   = 16'd2000;
   localparam logic [15:0] REPEAT_MS_RESET = 16'd200;
   localparam logic [15:0] SETTLE_MS_RESET = 16'd300;
   localparam logic [15:0] LIFT_MS_RESET   = 16'd3000;

   // key flag bit positions
   localparam int unsigned FLAG_UP   = 0;
   localparam int unsigned FLAG_DOWN = 1;
   localparam int unsigned FLAG_HOLD = 2;
   localparam int unsigned FLAG_LIFT = 3;

   localparam logic [3:0] PRESS_COUNT_MAX = 4'hF;

   typedef struct packed {
      logic        level;        // previous pressed state, 1 = pressed
      logic [3:0]  count;        // press count, saturating
      logic [3:0]  flags;        // up, down, hold done, lift done
      logic [15:0] change_time;  // time base at the last change
   } key_rec_type;

   localparam key_rec_type KEY_REC_RESET = '{
      level: 1'b0, count: 4'd0, flags: 4'b0001, change_time: 16'd0};

   typedef struct packed {
      logic [1:0] key;
      logic [2:0] code;
   } event_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } store_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_PASS1,
      ST_ELAPSE,
      ST_PASS2,
      ST_EMIT,
      ST_FLUSH
   } state_type;

endpackage

@@ sv/ker_req_if.sv @@
// ----------------------------------------------------------------------------
// ker_req_if
// Input channel: tick and scan words with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ker_req_if;
   logic       valid;
   logic       ready;
   logic       operation;
   logic [3:0] key_levels;

   modport source (output valid, output operation, output key_levels, input ready);
   modport sink (input valid, input operation, input key_levels, output ready);
endinterface

@@ sv/ker_rsp_if.sv @@
// ----------------------------------------------------------------------------
// ker_rsp_if
// Result channel: key event words with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ker_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] key_index;
   logic [2:0] event_code;
   logic       last;

   modport source (output valid, output key_index, output event_code, output last,
                   input ready);
   modport sink (input valid, input key_index, input event_code, input last,
                 output ready);
endinterface

@@ sv/ker_key_store.sv @@
// ----------------------------------------------------------------------------
// ker_key_store
// Per-key state memory, one port, registered read. An entry that was never
// written since reset reads as the reset record.
// ----------------------------------------------------------------------------
module ker_key_store #(
   parameter int KEYS = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  ker_pkg::store_ctl_type      ctl,
   input  logic [((KEYS > 1) ? $clog2(KEYS) : 1)-1:0] addr,
   input  ker_pkg::key_rec_type        wr_rec,
   output ker_pkg::key_rec_type        rd_rec
);

   ker_pkg::key_rec_type mem_ff [KEYS];
   ker_pkg::key_rec_type rd_data_ff;
   logic [KEYS-1:0]      written_ff;
   logic                 rd_written_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[addr] <= wr_rec;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff    <= '0;
         rd_written_ff <= 1'b0;
      end else begin
         if (ctl.wr_en) begin
            written_ff[addr] <= 1'b1;
         end
         if (ctl.rd_en) begin
            rd_written_ff <= written_ff[addr];
         end
      end
   end

   assign rd_rec = rd_written_ff ? rd_data_ff : ker_pkg::KEY_REC_RESET;

endmodule

@@ sv/key_event_recognizer.sv @@
// ----------------------------------------------------------------------------
// key_event_recognizer
// Multi-click and long-press detector: tick words advance a 16-bit time
// base, scan words produce down/up, hold, repeat, lift and click events.
// ----------------------------------------------------------------------------
// A tick word is taken while the sequencer is idle. A scan word runs two
// passes over the keys through the per-key state memory: the change pass
// steps through read, update and write back, and drain for each key, and
// the timing pass through read, elapsed time multiply, decide and write
// back, and drain. The drain step sends each event of the key and waits
// while the result side stalls; a final step closes the scan. The single
// port of the key memory and its registered read set this sequence. The
// next word is taken as soon as the last event of a scan has moved into
// the output register. The memory needs no clearing pass: unwritten
// entries read as their reset state.
module key_event_recognizer #(
   parameter int KEYS       = 4,
   parameter int TICK_MS    = 10,
   parameter int MAX_CLICKS = 3
) (
   input  logic                                  clock,
   input  logic                                  reset,
   ker_req_if.sink                               req_if,
   ker_rsp_if.source                             rsp_if,
   input  logic                                  csr_wr_en,
   input  logic [ker_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [ker_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam int KW    = (KEYS > 1) ? $clog2(KEYS) : 1;
   localparam int EW    = 16 + $clog2(TICK_MS + 1);
   // hold_ms / TICK_MS as a multiply by a rounded-up reciprocal
   localparam int SHIFT = 16 + $clog2(TICK_MS);
   localparam int RECIP = ((1 << SHIFT) + TICK_MS - 1) / TICK_MS;
   localparam int PW    = 16 + SHIFT + 1;

   function automatic logic ev_on(input logic [31:0] enable, input logic key_ok,
                                  input logic [1:0] key, input logic [2:0] code);
      return key_ok && enable[{key, code}];
   endfunction

   // configuration
   logic [15:0] hold_ms_ff, repeat_ms_ff, settle_ms_ff, lift_ms_ff;
   logic [31:0] event_enable_ff;
   logic        pressed_level_ff;
   logic [15:0] hold_ticks_ff;
   logic [PW-1:0] hold_prod;

   // sequencer and datapath
   ker_pkg::state_type   state_ff, state_in;
   logic [KW-1:0]        key_ff, key_in;
   logic                 pass2_ff, pass2_in;
   logic [15:0]          time_base_ff;
   logic [3:0]           levels_ff;
   logic [EW-1:0]        elapsed_ff;
   logic [EW-1:0]        elapsed_in;
   logic [15:0]          delta;

   ker_pkg::store_ctl_type store_ctl;
   ker_pkg::key_rec_type   rd_rec, wr_rec, p1_rec, p2_rec;

   // event buffer of one key step, pending word and output register
   logic [1:0]           ev_vld_ff;
   ker_pkg::event_type   ev0_ff, ev1_ff;
   logic                 pend_vld_ff;
   ker_pkg::event_type   pend_ff;
   logic                 rsp_vld_ff;
   ker_pkg::event_type   rsp_ev_ff;
   logic                 rsp_last_ff;

   logic        accept, out_free, can_push;
   logic        load_p1, load_p2, push, flush, last_key;
   logic [1:0]  key2;
   logic        key_ok;

   logic        lvl, pressed, changed, p1_ev;
   logic [2:0]  p1_code;

   logic        ge_hold, ge_repeat, ge_settle, ge_lift;
   logic        hold_ev, repeat_ev, click_ev, lift_ev;
   logic [2:0]  click_code;
   logic        a_vld, b_vld;
   ker_pkg::event_type a_ev, b_ev;

   assign accept   = req_if.valid && req_if.ready;
   assign out_free = !rsp_vld_ff || rsp_if.ready;
   assign can_push = !pend_vld_ff || out_free;
   assign key2     = 2'(key_ff);
   assign key_ok   = 32'(key_ff) < 32'(ker_pkg::LEVEL_KEYS);
   assign last_key = key_ff == KW'(KEYS - 1);

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ms_ff       <= ker_pkg::HOLD_MS_RESET;
         repeat_ms_ff     <= ker_pkg::REPEAT_MS_RESET;
         settle_ms_ff     <= ker_pkg::SETTLE_MS_RESET;
         lift_ms_ff       <= ker_pkg::LIFT_MS_RESET;
         event_enable_ff  <= '0;
         pressed_level_ff <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            ker_pkg::REG_HOLD_MS:       hold_ms_ff       <= csr_wdata[15:0];
            ker_pkg::REG_REPEAT_MS:     repeat_ms_ff     <= csr_wdata[15:0];
            ker_pkg::REG_SETTLE_MS:     settle_ms_ff     <= csr_wdata[15:0];
            ker_pkg::REG_LIFT_MS:       lift_ms_ff       <= csr_wdata[15:0];
            ker_pkg::REG_EVENT_ENABLE:  event_enable_ff  <= csr_wdata;
            ker_pkg::REG_PRESSED_LEVEL: pressed_level_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // hold time in ticks, a registered copy of the hold register divided by TICK_MS
   assign hold_prod = PW'(hold_ms_ff) * PW'(RECIP);
   always_ff @(posedge clock) begin
      hold_ticks_ff <= 16'(hold_prod >> SHIFT);
   end

   // ------------------------------------------------------------ key memory
   ker_key_store #(.KEYS(KEYS)) u_store (
      .clock  (clock),
      .reset  (reset),
      .ctl    (store_ctl),
      .addr   (key_ff),
      .wr_rec (wr_rec),
      .rd_rec (rd_rec)
   );

   // ---------------------------------------------------------- change pass
   always_comb begin
      lvl     = key_ok ? levels_ff[key2] : 1'b0;
      pressed = lvl == pressed_level_ff;
      changed = pressed != rd_rec.level;
      p1_rec  = rd_rec;
      p1_code = pressed ? ker_pkg::EV_DOWN : ker_pkg::EV_UP;
      if (changed) begin
         if (pressed) begin
            if (rd_rec.count != ker_pkg::PRESS_COUNT_MAX) begin
               p1_rec.count = rd_rec.count + 4'd1;
            end
            p1_rec.flags[ker_pkg::FLAG_UP]   = 1'b0;
            p1_rec.flags[ker_pkg::FLAG_DOWN] = 1'b1;
         end else begin
            p1_rec.flags[ker_pkg::FLAG_DOWN] = 1'b0;
            p1_rec.flags[ker_pkg::FLAG_UP]   = 1'b1;
         end
         p1_rec.change_time = time_base_ff;
         p1_rec.level       = pressed;
      end
      p1_ev = changed && ev_on(event_enable_ff, key_ok, key2, p1_code);
   end

   // ---------------------------------------------------------- timing pass
   assign delta      = time_base_ff - rd_rec.change_time;
   assign elapsed_in = EW'(delta) * EW'(TICK_MS);

   always_ff @(posedge clock) begin
      elapsed_ff <= elapsed_in;
   end

   always_comb begin
      ge_hold    = elapsed_ff >= EW'(hold_ms_ff);
      ge_repeat  = elapsed_ff >= EW'({1'b0, hold_ms_ff} + {1'b0, repeat_ms_ff});
      ge_settle  = elapsed_ff >= EW'(settle_ms_ff);
      ge_lift    = elapsed_ff >= EW'(lift_ms_ff);
      hold_ev    = 1'b0;
      repeat_ev  = 1'b0;
      click_ev   = 1'b0;
      lift_ev    = 1'b0;
      click_code = ker_pkg::EV_CLICK_BASE + rd_rec.count[2:0];
      p2_rec     = rd_rec;
      if (rd_rec.count != 4'd0) begin
         if (rd_rec.flags[ker_pkg::FLAG_DOWN]) begin
            if (ev_on(event_enable_ff, key_ok, key2, ker_pkg::EV_HOLD) &&
                !rd_rec.flags[ker_pkg::FLAG_HOLD] && ge_hold) begin
               hold_ev = 1'b1;
               p2_rec.flags[ker_pkg::FLAG_HOLD] = 1'b1;
            end
            if (ev_on(event_enable_ff, key_ok, key2, ker_pkg::EV_REPEAT) &&
                ge_hold && ge_repeat) begin
               repeat_ev = 1'b1;
               // restart the repeat period from the end of the hold time
               p2_rec.change_time = time_base_ff - hold_ticks_ff;
               p2_rec.flags[ker_pkg::FLAG_HOLD] = 1'b1;
            end
         end else if (ge_settle) begin
            if (rd_rec.flags[ker_pkg::FLAG_HOLD]) begin
               p2_rec.flags[ker_pkg::FLAG_HOLD] = 1'b0;
            end else if (rd_rec.count <= 4'(MAX_CLICKS) &&
                         rd_rec.count <= ker_pkg::LAST_CLICK_COUNT) begin
               click_ev = ev_on(event_enable_ff, key_ok, key2, click_code);
            end
            p2_rec.count = 4'd0;
            p2_rec.flags[ker_pkg::FLAG_LIFT] = 1'b0;
         end
      end
      if (p2_rec.count == 4'd0 &&
          ev_on(event_enable_ff, key_ok, key2, ker_pkg::EV_LIFT) &&
          !p2_rec.flags[ker_pkg::FLAG_LIFT] && ge_lift) begin
         lift_ev = 1'b1;
         p2_rec.flags[ker_pkg::FLAG_LIFT] = 1'b1;
      end
      // hold and click exclude each other, so do repeat and lift
      a_vld     = hold_ev || click_ev;
      a_ev.key  = key2;
      a_ev.code = hold_ev ? ker_pkg::EV_HOLD : click_code;
      b_vld     = repeat_ev || lift_ev;
      b_ev.key  = key2;
      b_ev.code = repeat_ev ? ker_pkg::EV_REPEAT : ker_pkg::EV_LIFT;
   end

   // ------------------------------------------------------------- sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ker_pkg::ST_IDLE;
         key_ff   <= '0;
         pass2_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         key_ff   <= key_in;
         pass2_ff <= pass2_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      key_in        = key_ff;
      pass2_in      = pass2_ff;
      store_ctl     = '0;
      wr_rec        = p1_rec;
      load_p1       = 1'b0;
      load_p2       = 1'b0;
      push          = 1'b0;
      flush         = 1'b0;
      req_if.ready  = 1'b0;
      unique case (state_ff)
         ker_pkg::ST_IDLE: begin
            req_if.ready = 1'b1;
            if (req_if.valid && req_if.operation == ker_pkg::OP_SCAN) begin
               key_in   = '0;
               pass2_in = 1'b0;
               state_in = ker_pkg::ST_READ;
            end
         end
         ker_pkg::ST_READ: begin
            store_ctl.rd_en = 1'b1;
            state_in = pass2_ff ? ker_pkg::ST_ELAPSE : ker_pkg::ST_PASS1;
         end
         ker_pkg::ST_PASS1: begin
            // the write lands before the next read of any entry
            store_ctl.wr_en = 1'b1;
            wr_rec   = p1_rec;
            load_p1  = 1'b1;
            state_in = ker_pkg::ST_EMIT;
         end
         ker_pkg::ST_ELAPSE: begin
            state_in = ker_pkg::ST_PASS2;
         end
         ker_pkg::ST_PASS2: begin
            store_ctl.wr_en = 1'b1;
            wr_rec   = p2_rec;
            load_p2  = 1'b1;
            state_in = ker_pkg::ST_EMIT;
         end
         ker_pkg::ST_EMIT: begin
            if (ev_vld_ff[0]) begin
               push = can_push;
            end else if (!last_key) begin
               key_in   = key_ff + KW'(1);
               state_in = ker_pkg::ST_READ;
            end else if (!pass2_ff) begin
               key_in   = '0;
               pass2_in = 1'b1;
               state_in = ker_pkg::ST_READ;
            end else begin
               state_in = ker_pkg::ST_FLUSH;
            end
         end
         ker_pkg::ST_FLUSH: begin
            // the held word is the final one of the scan
            if (!pend_vld_ff) begin
               state_in = ker_pkg::ST_IDLE;
            end else if (out_free) begin
               flush    = 1'b1;
               state_in = ker_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ker_pkg::ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------- datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         time_base_ff <= '0;
      end else if (accept && req_if.operation == ker_pkg::OP_TICK) begin
         time_base_ff <= time_base_ff + 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         levels_ff <= req_if.key_levels;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ev_vld_ff <= '0;
      end else if (load_p1) begin
         ev_vld_ff <= {1'b0, p1_ev};
      end else if (load_p2) begin
         ev_vld_ff <= {a_vld && b_vld, a_vld || b_vld};
      end else if (push) begin
         ev_vld_ff <= {1'b0, ev_vld_ff[1]};
      end
   end

   always_ff @(posedge clock) begin
      if (load_p1) begin
         ev0_ff <= '{key: key2, code: p1_code};
      end else if (load_p2) begin
         ev0_ff <= a_vld ? a_ev : b_ev;
         ev1_ff <= b_ev;
      end else if (push) begin
         ev0_ff <= ev1_ff;
      end
   end

   // one word is held back until the next one shows whether it is the last
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_vld_ff <= 1'b0;
      end else if (push) begin
         pend_vld_ff <= 1'b1;
      end else if (flush) begin
         pend_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         pend_ff <= ev0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if ((push && pend_vld_ff) || flush) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((push && pend_vld_ff) || flush) begin
         rsp_ev_ff   <= pend_ff;
         rsp_last_ff <= flush;
      end
   end

   assign rsp_if.valid      = rsp_vld_ff;
   assign rsp_if.key_index  = rsp_ev_ff.key;
   assign rsp_if.event_code = rsp_ev_ff.code;
   assign rsp_if.last       = rsp_last_ff;

   // ------------------------------------------------------------ assertions
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff == ker_pkg::ST_IDLE |-> !pend_vld_ff)
      else $error("pending event left behind at end of scan");

   a_not_last_has_follower: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && !rsp_last_ff |-> pend_vld_ff)
      else $error("non-final event word with no event after it");

   a_emit_drained: assert property (@(posedge clock) disable iff (reset)
      state_ff == ker_pkg::ST_EMIT && state_in != ker_pkg::ST_EMIT |-> !ev_vld_ff[0])
      else $error("key step left with events still buffered");

   a_mem_one_access: assert property (@(posedge clock) disable iff (reset)
      store_ctl.wr_en |=> !store_ctl.wr_en)
      else $error("back-to-back key memory writes");

endmodule

@@ tb/key_event_recognizer_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// key_event_recognizer_tb
// Drives tick and scan words into the key event recognizer, follows every
// accepted word with a cycle-free copy of the per-key timing rules and checks
// each key event word, field by field and in order, against that copy. A
// short directed table comes first, then randomized press/release sequences
// under several register settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module key_event_recognizer_tb;

   localparam int unsigned KEYS           = 4;
   localparam int unsigned TICK_MS        = 10;
   localparam int unsigned MAX_CLICKS     = 3;
   localparam int unsigned MAX_EVENTS     = 12;
   localparam int unsigned DRAIN_CYCLES   = 80;
   localparam int unsigned WATCHDOG_LIMIT = 3000;

   // indexes that map to no register
   localparam logic [ker_pkg::CSR_INDEX_W-1:0] REG_UNMAPPED_A = 3'd6;
   localparam logic [ker_pkg::CSR_INDEX_W-1:0] REG_UNMAPPED_B = 3'd7;

   // short names for the table
   localparam logic TICK = ker_pkg::OP_TICK;
   localparam logic SCAN = ker_pkg::OP_SCAN;

   typedef struct packed {
      logic [1:0] key;
      logic [2:0] code;
      logic       last;
   } key_event_type;

   typedef enum logic [1:0] {ROW_REG, ROW_PREDICT, ROW_QUIET, ROW_SINGLE} row_kind_type;

   typedef struct packed {
      row_kind_type                    kind;
      logic [ker_pkg::CSR_INDEX_W-1:0] idx;
      logic [ker_pkg::CSR_DATA_W-1:0]  data;
      logic                            op;
      logic [3:0]                      levels;
      logic [1:0]                      key;
      logic [2:0]                      code;
   } stim_row_type;

   logic                            clock;
   logic                            reset;
   logic                            csr_wr_en;
   logic [ker_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [ker_pkg::CSR_DATA_W-1:0]  csr_wdata;

   ker_req_if req ();
   ker_rsp_if rsp ();

   key_event_recognizer #(
      .KEYS(KEYS),
      .TICK_MS(TICK_MS),
      .MAX_CLICKS(MAX_CLICKS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_if(req),
      .rsp_if(rsp),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // predictor state and register copies
   logic [15:0]          time_base;
   ker_pkg::key_rec_type keys [KEYS];
   logic [15:0]          hold_ms;
   logic [15:0]          repeat_ms;
   logic [15:0]          settle_ms;
   logic [15:0]          lift_ms;
   logic [31:0]          event_enable;
   logic                 press_level;

   key_event_type scan_events [$];
   key_event_type expected_events [$];

   logic [3:0] raw_levels;
   bit         steady;
   int         mismatches;
   int         ticks_sent;
   int         scans_sent;
   int         events_checked;
   int         settings_used;
   int         code_seen [8];
   int         quiet_cycles;

   stim_row_type directed_rows [34] = '{
      '{ROW_QUIET, ker_pkg::REG_HOLD_MS, 32'h0, SCAN, 4'hF, 2'd0, ker_pkg::EV_DOWN},
      '{ROW_QUIET, ker_pkg::REG_HOLD_MS, 32'h0, SCAN, 4'h0, 2'd0, ker_pkg::EV_DOWN},
      '{ROW_QUIET, ker_pkg::REG_HOLD_MS, 32'h0, TICK, 4'h5, 2'd0, ker_pkg::EV_DOWN},
      '{ROW_REG, ker_pkg::REG_HOLD_MS, 32'hABCD_001E, TICK, 4'h0, 2'd0, ker_pkg::EV_DOWN},
      '{ROW_REG, ker_pkg::REG_REPEAT_MS, 32'h0000_0014, TICK, 4'h0, 2'd0, ker_pkg::EV_DOWN},
      '{ROW_REG, ker_pkg::REG_SETTLE_MS, 32'hFFFF_001E, TICK, 4'h0, 2'd0, ker_pkg::EV_DOWN},
      '{ROW_REG, ker_pkg::REG_LIFT_MS, 32'h5A5A_0032, TICK, 4'h0, 2'd0, ker_pkg::EV_DOWN},
      '{ROW_REG, ker_pkg::REG_EVENT_ENABLE, 32'hFFFF_FFFF, TICK, 4'h0, 2'd0, ker_pkg::EV_DOWN},
      '{ROW_REG, ker_pkg::REG_PRESSED_LEVEL, 32'h8000_0001, TICK, 4'h0, 2'd0, ker_pkg::EV_DOWN},
      '{ROW_REG, REG_UNMAPPED_A, 32'hFFFF_FFFF, TICK, 4'h0, 2'd0, ker_pkg::EV_DOWN},
      '{ROW_REG, REG_UNMAPPED_B, 32'h0000_0000, TICK, 4'h0, 2'd0, ker_pkg::EV_DOWN},
      // up on every key, then key 0 pressed twice and key 1 three times more, for press counts of three and four
      '{ROW_PREDICT, ker_pkg::REG_HOLD_MS, 32'h0, SCAN, 4'h0, 2'd0, ker_pkg::EV_DOWN},
      '{ROW_PREDICT, ker_pkg::REG_HOLD_MS, 32'h0, SCAN, 4'h3, 2'd0, ker_pkg::EV_DOWN},
      '{ROW_PREDICT, ker_pkg::REG_HOLD_MS, 32'h0, SCAN, 4'h0, 2'd0, ker_pkg::EV_DOWN},
      '{ROW_PREDICT, ker_pkg::REG_HOLD_MS, 32'h0, SCAN, 4'h3, 2'd0, ker_pkg::EV_DOWN},
      '{ROW_PREDICT, ker_pkg::REG_HOLD_MS, 32'h0, SCAN, 4'h0, 2'd0, ker_pkg::EV_DOWN},
      '{ROW_PREDICT, ker_pkg::REG_HOLD_MS, 32'h0, SCAN, 4'h2, 2'd0, ker_pkg::EV_DOWN},
      '{ROW_PREDICT, ker_pkg::REG_HOLD_MS, 32'h0, SCAN, 4'h0, 2'd0, ker_pkg::EV_DOWN},
      '{ROW_QUIET, ker_pkg::REG_HOLD_MS, 32'h0, TICK, 4'hA, 2'd0, ker_pkg::EV_DOWN},
      '{ROW_QUIET, ker_pkg::REG_HOLD_MS, 32'h0, TICK, 4'h5, 2'd0, ker_pkg::EV_DOWN},
      '{ROW_QUIET, ker_pkg::REG_HOLD_MS, 32'h0, TICK, 4'hF, 2'd0, ker_pkg::EV_DOWN},
      // triple on key 0, nothing past the last click code on key 1
      '{ROW_PREDICT, ker_pkg::REG_HOLD_MS, 32'h0, SCAN, 4'h0, 2'd0, ker_pkg::EV_DOWN},
      '{ROW_SINGLE, ker_pkg::REG_HOLD_MS, 32'h0, SCAN, 4'h4, 2'd2, ker_pkg::EV_DOWN},
      '{ROW_QUIET, ker_pkg::REG_HOLD_MS, 32'h0, TICK, 4'h0, 2'd0, ker_pkg::EV_DOWN},
      '{ROW_QUIET, ker_pkg::REG_HOLD_MS, 32'h0, TICK, 4'h1, 2'd0, ker_pkg::EV_DOWN},
      '{ROW_QUIET, ker_pkg::REG_HOLD_MS, 32'h0, TICK, 4'h2, 2'd0, ker_pkg::EV_DOWN},
      '{ROW_QUIET, ker_pkg::REG_HOLD_MS, 32'h0, TICK, 4'h4, 2'd0, ker_pkg::EV_DOWN},
      '{ROW_QUIET, ker_pkg::REG_HOLD_MS, 32'h0, TICK, 4'h8, 2'd0, ker_pkg::EV_DOWN},
      // hold and repeat on key 2, lift on the others
      '{ROW_PREDICT, ker_pkg::REG_HOLD_MS, 32'h0, SCAN, 4'h4, 2'd0, ker_pkg::EV_DOWN},
      '{ROW_SINGLE, ker_pkg::REG_HOLD_MS, 32'h0, SCAN, 4'h0, 2'd2, ker_pkg::EV_UP},
      '{ROW_QUIET, ker_pkg::REG_HOLD_MS, 32'h0, TICK, 4'h3, 2'd0, ker_pkg::EV_DOWN},
      '{ROW_QUIET, ker_pkg::REG_HOLD_MS, 32'h0, TICK, 4'hC, 2'd0, ker_pkg::EV_DOWN},
      '{ROW_QUIET, ker_pkg::REG_HOLD_MS, 32'h0, TICK, 4'h9, 2'd0, ker_pkg::EV_DOWN},
      // release after hold closes without a click
      '{ROW_PREDICT, ker_pkg::REG_HOLD_MS, 32'h0, SCAN, 4'h0, 2'd0, ker_pkg::EV_DOWN}
   };

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic bit event_on(int unsigned k, logic [2:0] code);
      return event_enable[8 * k + code];
   endfunction

   function automatic void add_event(int unsigned k, logic [2:0] code);
      if (event_on(k, code) && scan_events.size() < MAX_EVENTS)
         scan_events.push_back('{key: k[1:0], code: code, last: 1'b0});
   endfunction

   // advances the key state by one word and leaves its events in scan_events
   function automatic void predict_events(logic op, logic [3:0] lv);
      logic          pressed;
      logic [31:0]   elapsed;
      key_event_type tail;
      scan_events.delete();
      if (op == ker_pkg::OP_TICK) begin
         time_base = time_base + 16'd1;
         return;
      end
      for (int unsigned k = 0; k < KEYS; k++) begin
         pressed = (lv[k] == press_level);
         if (pressed != keys[k].level) begin
            if (pressed) begin
               if (keys[k].count != ker_pkg::PRESS_COUNT_MAX)
                  keys[k].count = keys[k].count + 4'd1;
               add_event(k, ker_pkg::EV_DOWN);
               keys[k].flags[ker_pkg::FLAG_UP] = 1'b0;
               keys[k].flags[ker_pkg::FLAG_DOWN] = 1'b1;
            end else begin
               add_event(k, ker_pkg::EV_UP);
               keys[k].flags[ker_pkg::FLAG_DOWN] = 1'b0;
               keys[k].flags[ker_pkg::FLAG_UP] = 1'b1;
            end
            keys[k].change_time = time_base;
            keys[k].level = pressed;
         end
      end
      for (int unsigned k = 0; k < KEYS; k++) begin
         elapsed = 32'(16'(time_base - keys[k].change_time)) * TICK_MS;
         if (keys[k].count != 4'd0) begin
            if (keys[k].flags[ker_pkg::FLAG_DOWN]) begin
               if (event_on(k, ker_pkg::EV_HOLD) && !keys[k].flags[ker_pkg::FLAG_HOLD]
                   && elapsed >= hold_ms) begin
                  add_event(k, ker_pkg::EV_HOLD);
                  keys[k].flags[ker_pkg::FLAG_HOLD] = 1'b1;
               end
               if (event_on(k, ker_pkg::EV_REPEAT) && elapsed >= hold_ms
                   && elapsed >= 32'(hold_ms) + 32'(repeat_ms)) begin
                  add_event(k, ker_pkg::EV_REPEAT);
                  // next repeat one period later
                  keys[k].change_time = time_base - 16'(hold_ms / TICK_MS);
                  keys[k].flags[ker_pkg::FLAG_HOLD] = 1'b1;
               end
            end else if (elapsed >= settle_ms) begin
               if (keys[k].flags[ker_pkg::FLAG_HOLD]) begin
                  keys[k].flags[ker_pkg::FLAG_HOLD] = 1'b0;
               end else if (keys[k].count <= MAX_CLICKS
                            && keys[k].count <= ker_pkg::LAST_CLICK_COUNT) begin
                  add_event(k, ker_pkg::EV_CLICK_BASE + 3'(keys[k].count));
               end
               keys[k].count = 4'd0;
               keys[k].flags[ker_pkg::FLAG_LIFT] = 1'b0;
            end
         end
         if (keys[k].count == 4'd0) begin
            if (event_on(k, ker_pkg::EV_LIFT) && !keys[k].flags[ker_pkg::FLAG_LIFT]
                && elapsed >= lift_ms) begin
               add_event(k, ker_pkg::EV_LIFT);
               keys[k].flags[ker_pkg::FLAG_LIFT] = 1'b1;
            end
         end
      end
      if (scan_events.size() != 0) begin
         tail = scan_events.pop_back();
         tail.last = 1'b1;
         scan_events.push_back(tail);
      end
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH @%0t: %s", $time, what);
      mismatches++;
   endtask

   // offers one word and returns at the edge that takes it
   task automatic present_word(input logic op, input logic [3:0] lv);
      while (!steady && $urandom_range(0, 99) < 24) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.operation <= op;
      req.key_levels <= lv;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      if (op == ker_pkg::OP_SCAN) begin
         scans_sent++;
         raw_levels = lv;
      end else begin
         ticks_sent++;
      end
      predict_events(op, lv);
   endtask

   task automatic send_word(input logic op, input logic [3:0] lv);
      present_word(op, lv);
      foreach (scan_events[i]) expected_events.push_back(scan_events[i]);
   endtask

   task automatic wait_idle();
      req.valid <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      // a scan with no events may still be running
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [ker_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [ker_pkg::CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      case (idx)
         ker_pkg::REG_HOLD_MS: hold_ms = data[15:0];
         ker_pkg::REG_REPEAT_MS: repeat_ms = data[15:0];
         ker_pkg::REG_SETTLE_MS: settle_ms = data[15:0];
         ker_pkg::REG_LIFT_MS: lift_ms = data[15:0];
         ker_pkg::REG_EVENT_ENABLE: event_enable = data;
         ker_pkg::REG_PRESSED_LEVEL: press_level = data[0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [15:0] hold, input logic [15:0] period,
                                 input logic [15:0] settle, input logic [15:0] lift,
                                 input logic [31:0] enable, input logic level);
      wait_idle();
      // upper bits carry noise that the block must drop
      write_reg(ker_pkg::REG_HOLD_MS, {16'($urandom), hold});
      write_reg(ker_pkg::REG_REPEAT_MS, {16'($urandom), period});
      write_reg(ker_pkg::REG_SETTLE_MS, {16'($urandom), settle});
      write_reg(ker_pkg::REG_LIFT_MS, {16'($urandom), lift});
      write_reg(ker_pkg::REG_EVENT_ENABLE, enable);
      write_reg(ker_pkg::REG_PRESSED_LEVEL, {31'($urandom), level});
      settings_used++;
   endtask

   task automatic run_random(input int n_words);
      int          stop_at;
      int unsigned k;
      int          presses;
      logic [3:0]  lv;
      stop_at = ticks_sent + scans_sent + n_words;
      while (ticks_sent + scans_sent < stop_at) begin
         case ($urandom_range(0, 9))
            0: send_word(SCAN, 4'($urandom));
            1: repeat ($urandom_range(1, 6)) send_word(TICK, 4'($urandom));
            default: begin
               // one key pressed and released a few times, now and then past saturation
               k = $urandom_range(0, KEYS - 1);
               presses = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 17)
                                                     : $urandom_range(1, 3);
               repeat (presses) begin
                  lv = raw_levels;
                  lv[k] = press_level;
                  send_word(SCAN, lv);
                  // keep it held and rescan so hold and repeat can fire
                  if ($urandom_range(0, 3) == 0) begin
                     repeat ($urandom_range(1, 6)) begin
                        repeat ($urandom_range(1, 3)) send_word(TICK, 4'($urandom));
                        send_word(SCAN, raw_levels);
                     end
                  end
                  lv = raw_levels;
                  lv[k] = ~press_level;
                  send_word(SCAN, lv);
                  if ($urandom_range(0, 1) == 1) send_word(TICK, 4'($urandom));
               end
               repeat ($urandom_range(0, 8)) send_word(TICK, 4'($urandom));
               send_word(SCAN, raw_levels);
            end
         endcase
      end
   endtask

   // result side: random back-pressure and in-order compare
   initial begin
      key_event_type want;
      rsp.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
            if (expected_events.size() == 0) begin
               report_mismatch($sformatf("unexpected event key %0d code %0d last %0d",
                                         rsp.key_index, rsp.event_code, rsp.last));
            end else begin
               want = expected_events.pop_front();
               if (rsp.key_index !== want.key)
                  report_mismatch($sformatf("key_index %0d, want %0d",
                                            rsp.key_index, want.key));
               if (rsp.event_code !== want.code)
                  report_mismatch($sformatf("event_code %0d, want %0d (key %0d)",
                                            rsp.event_code, want.code, want.key));
               if (rsp.last !== want.last)
                  report_mismatch($sformatf("last %0d, want %0d (key %0d code %0d)",
                                            rsp.last, want.last, want.key, want.code));
               events_checked++;
               code_seen[want.code]++;
            end
         end
         rsp.ready <= steady || ($urandom_range(0, 99) >= 24);
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      bit prev_reg;
      req.valid <= 1'b0;
      req.operation <= ker_pkg::OP_TICK;
      req.key_levels <= 4'h0;
      csr_wr_en <= 1'b0;
      csr_index <= ker_pkg::REG_HOLD_MS;
      csr_wdata <= '0;
      reset <= 1'b1;
      time_base = 16'd0;
      foreach (keys[k]) keys[k] = ker_pkg::KEY_REC_RESET;
      hold_ms = ker_pkg::HOLD_MS_RESET;
      repeat_ms = ker_pkg::REPEAT_MS_RESET;
      settle_ms = ker_pkg::SETTLE_MS_RESET;
      lift_ms = ker_pkg::LIFT_MS_RESET;
      event_enable = '0;
      press_level = 1'b0;
      raw_levels = 4'hF;
      prev_reg = 1'b0;
      settings_used = 1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         case (directed_rows[i].kind)
            ROW_REG: begin
               if (!prev_reg) wait_idle();
               write_reg(directed_rows[i].idx, directed_rows[i].data);
            end
            ROW_PREDICT: send_word(directed_rows[i].op, directed_rows[i].levels);
            ROW_QUIET: present_word(directed_rows[i].op, directed_rows[i].levels);
            ROW_SINGLE: begin
               present_word(directed_rows[i].op, directed_rows[i].levels);
               expected_events.push_back('{key: directed_rows[i].key,
                                           code: directed_rows[i].code, last: 1'b1});
            end
         endcase
         if (directed_rows[i].kind == ROW_REG && !prev_reg) settings_used++;
         prev_reg = (directed_rows[i].kind == ROW_REG);
      end

      apply_settings(16'd30, 16'd20, 16'd30, 16'd50, 32'hFFFF_FFFF, 1'b1);
      run_random(25);
      apply_settings(16'd0, 16'd0, 16'd0, 16'd0, $urandom, 1'b0);
      run_random(20);
      // a stretch with no random idling on either channel
      steady = 1'b1;
      apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
      run_random(20);
      steady = 1'b0;
      apply_settings(16'($urandom_range(0, 80)), 16'($urandom_range(0, 60)),
                     16'($urandom_range(0, 60)), 16'($urandom_range(0, 120)),
                     $urandom | $urandom, 1'($urandom));
      run_random(25);
      apply_settings(16'd20, 16'd10, 16'd40, 16'd30, 32'hFFFF_FFFF, 1'b0);
      run_random(20);

      wait_idle();
      if (expected_events.size() != 0)
         report_mismatch($sformatf("%0d events never arrived", expected_events.size()));

      $display("covered %0d ticks and %0d scans over %0d register settings, %0d events checked",
               ticks_sent, scans_sent, settings_used, events_checked);
      $display("down %0d up %0d hold %0d repeat %0d lift %0d single %0d double %0d triple %0d",
               code_seen[0], code_seen[1], code_seen[2], code_seen[3],
               code_seen[4], code_seen[5], code_seen[6], code_seen[7]);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
sv/ker_pkg.sv
sv/ker_req_if.sv
sv/ker_rsp_if.sv
sv/ker_key_store.sv
sv/key_event_recognizer.sv
tb/key_event_recognizer_tb.sv
